@@ rtl/assert_macros.svh @@
// Assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, a, c)
`define ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

@@ rtl/rth_pkg.sv @@
package rth_pkg;
  localparam int unsigned Scale = 240;
  localparam int unsigned DivSteps = 17;

  typedef enum logic [1:0] {
    MAX_RED   = 2'd0,
    MAX_GREEN = 2'd1,
    MAX_BLUE  = 2'd2
  } max_sel_t;

  typedef struct packed {
    max_sel_t    sel;
    logic [7:0]  c;
    logic [10:0] base;
    logic [8:0]  sum;
    logic [7:0]  light;
  } cls_t;

  typedef struct packed {
    logic [7:0] hue;
    logic [7:0] saturation;
    logic [7:0] lightness;
    logic [8:0] lightness_sum;
  } hsl_t;
endpackage

@@ rtl/rth_if.sv @@
interface rth_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  modport source (output valid, red, green, blue, input ready);
  modport sink (input valid, red, green, blue, output ready);
endinterface

interface rth_hsl_if;
  logic       valid;
  logic       ready;
  logic [7:0] hue;
  logic [7:0] saturation;
  logic [7:0] lightness;
  logic [8:0] lightness_sum;
  modport source (output valid, hue, saturation, lightness, lightness_sum, input ready);
  modport sink (input valid, hue, saturation, lightness, lightness_sum, output ready);
endinterface

@@ rtl/rth_front.sv @@
module rth_front (
  input  logic           clk,
  input  logic           rst,
  rth_pix_if.sink        pix,
  output logic           cls_valid,
  input  logic           cls_ready,
  output rth_pkg::cls_t  cls
);
  logic [7:0] mx, mn, c;
  logic [8:0] sum;
  logic [12:0] s8;
  logic [23:0] lprod;
  rth_pkg::cls_t cls_next;

  always_comb begin
    mx = pix.red;
    if (pix.green > mx) mx = pix.green;
    if (pix.blue > mx) mx = pix.blue;
    mn = pix.red;
    if (pix.green < mn) mn = pix.green;
    if (pix.blue < mn) mn = pix.blue;
    c = mx - mn;
    sum = {1'b0, mx} + {1'b0, mn};
    s8 = {sum, 3'b000};
    // x/17 = ((x+1)*3855)>>16 for x < 65536
    lprod = 24'({11'd0, s8} * 24'd3855 + 24'd3855) >> 16;
    cls_next.c = c;
    cls_next.sum = sum;
    cls_next.light = lprod[7:0];
    if (pix.red >= pix.green && pix.red >= pix.blue) begin
      cls_next.sel = rth_pkg::MAX_RED;
      cls_next.base = 11'({3'b0, c} * 11'd6 + {3'b0, pix.green} - {3'b0, pix.blue});
    end else if (pix.green >= pix.blue) begin
      cls_next.sel = rth_pkg::MAX_GREEN;
      cls_next.base = 11'({3'b0, c} * 11'd2 + {3'b0, pix.blue} - {3'b0, pix.red});
    end else begin
      cls_next.sel = rth_pkg::MAX_BLUE;
      cls_next.base = 11'({3'b0, c} * 11'd4 + {3'b0, pix.red} - {3'b0, pix.green});
    end
  end

  assign pix.ready = !cls_valid || cls_ready;

  always_ff @(posedge clk) begin
    if (rst) cls_valid <= 1'b0;
    else if (pix.ready) cls_valid <= pix.valid;
    if (pix.ready && pix.valid) cls <= cls_next;
  end
endmodule

@@ rtl/rth_queue.sv @@
module rth_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  rth_pkg::cls_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output rth_pkg::cls_t  out_data
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  rth_pkg::cls_t slot [DEPTH];
  logic [AW-1:0] wp, rp;
  logic [AW:0] cnt;
  logic wr, rd;

  assign in_ready = cnt != (AW+1)'(DEPTH);
  assign out_valid = cnt != '0;
  assign out_data = slot[rp];
  assign wr = in_valid && in_ready;
  assign rd = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      if (wr) wp <= (wp == AW'(DEPTH-1)) ? '0 : wp + 1'b1;
      if (rd) rp <= (rp == AW'(DEPTH-1)) ? '0 : rp + 1'b1;
      cnt <= cnt + (AW+1)'(wr) - (AW+1)'(rd);
    end
    if (wr) slot[wp] <= in_data;
  end

  `include "assert_macros.svh"
  `ASSERT_IMPLIES(a_no_over, clk, rst, cnt == (AW+1)'(DEPTH), !in_ready)
  `ASSERT_NEXT(a_cnt_up, clk, rst, wr && !rd, cnt == $past(cnt) + 1'b1)
  `ASSERT_NEXT(a_cnt_dn, clk, rst, rd && !wr, cnt == $past(cnt) - 1'b1)
endmodule

@@ rtl/rth_back.sv @@
module rth_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           cls_valid,
  output logic           cls_ready,
  input  rth_pkg::cls_t  cls,
  rth_hsl_if.source      hsl
);
  localparam int unsigned N = rth_pkg::DivSteps;
  // two restoring dividers, one quotient bit per stage
  logic        v [N+1];
  logic [17:0] hn [N+1];
  logic [16:0] hq [N+1];
  logic [8:0]  hd [N+1];
  logic [16:0] sn [N+1];
  logic [16:0] sq [N+1];
  logic [8:0]  sd [N+1];
  logic        zc [N+1], zd [N+1];
  logic [7:0]  lt [N+1];
  logic [8:0]  sm [N+1];
  logic adv;
  logic [8:0] dev, div;
  logic [8:0] l2;
  logic [7:0] hue_w, sat_w;

  assign adv = !hsl.valid || hsl.ready;
  assign cls_ready = adv;

  always_comb begin
    l2 = {cls.light, 1'b0};
    dev = (l2 >= 9'd240) ? l2 - 9'd240 : 9'd240 - l2;
    div = (dev >= 9'd240) ? 9'd0 : 9'd240 - dev;
    v[0] = cls_valid;
    hn[0] = 18'({7'd0, cls.base} * 18'd80) + {10'd0, cls.c};
    hq[0] = '0;
    hd[0] = {cls.c, 1'b0};
    sn[0] = 17'({9'd0, cls.c} * 17'd240);
    sq[0] = '0;
    sd[0] = div;
    zc[0] = cls.c == 8'd0;
    zd[0] = div == 9'd0;
    lt[0] = cls.light;
    sm[0] = cls.sum;
  end

  for (genvar i = 0; i < N; i++) begin : g_div
    localparam int unsigned Sh = N - 1 - i;
    logic [25:0] htr, str;
    assign htr = {8'd0, hn[i]} - ({17'd0, hd[i]} << Sh);
    assign str = {9'd0, sn[i]} - ({17'd0, sd[i]} << Sh);
    always_ff @(posedge clk) begin
      if (rst) v[i+1] <= 1'b0;
      else if (adv) v[i+1] <= v[i];
      if (adv) begin
        hn[i+1] <= htr[25] ? hn[i] : htr[17:0];
        hq[i+1] <= {hq[i][15:0], !htr[25]};
        sn[i+1] <= str[25] ? sn[i] : str[16:0];
        sq[i+1] <= {sq[i][15:0], !str[25]};
        hd[i+1] <= hd[i]; sd[i+1] <= sd[i];
        zc[i+1] <= zc[i]; zd[i+1] <= zd[i];
        lt[i+1] <= lt[i]; sm[i+1] <= sm[i];
      end
    end
  end

  always_comb begin
    if (zc[N]) hue_w = 8'd0;
    else if (hq[N] >= 17'd480) hue_w = 8'(hq[N] - 17'd480);
    else if (hq[N] >= 17'd240) hue_w = 8'(hq[N] - 17'd240);
    else hue_w = 8'(hq[N]);
    if (zc[N]) sat_w = 8'd0;
    else if (zd[N] || sq[N] > 17'd240) sat_w = 8'd240;
    else sat_w = 8'(sq[N]);
  end

  always_ff @(posedge clk) begin
    if (rst) hsl.valid <= 1'b0;
    else if (adv) hsl.valid <= v[N];
    if (adv) begin
      hsl.hue <= hue_w;
      hsl.saturation <= sat_w;
      hsl.lightness <= lt[N];
      hsl.lightness_sum <= sm[N];
    end
  end

  `include "assert_macros.svh"
  `ASSERT_IMPLIES(a_hue_rng, clk, rst, hsl.valid, hsl.hue < 8'd240)
  `ASSERT_IMPLIES(a_sat_rng, clk, rst, hsl.valid, hsl.saturation <= 8'd240)
  `ASSERT_NEXT(a_hold, clk, rst, hsl.valid && !hsl.ready, hsl.valid && $stable(hsl.hue))
endmodule

@@ rtl/rgb_to_hsl_240.sv @@
// Path: front register, queue, divider stages and output register, in that order.
// Throughput: one pixel per cycle while hsl.ready holds; the back end is a 17-stage pipelined pair
// of restoring dividers (hue and saturation), one quotient bit per stage.
// Reset: synchronous active-high rst clears all valid flags and the queue;
// payload registers are not reset.
module rgb_to_hsl_240 #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input logic        clk,
  input logic        rst,
  rth_pix_if.sink    pix,
  rth_hsl_if.source  hsl
);
  logic f_valid, f_ready, q_valid, q_ready;
  rth_pkg::cls_t f_data, q_data;

  rth_front u_front (.clk, .rst, .pix, .cls_valid(f_valid), .cls_ready(f_ready),
    .cls(f_data));
  rth_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (.clk, .rst, .in_valid(f_valid),
    .in_ready(f_ready), .in_data(f_data), .out_valid(q_valid), .out_ready(q_ready),
    .out_data(q_data));
  rth_back u_back (.clk, .rst, .cls_valid(q_valid), .cls_ready(q_ready), .cls(q_data),
    .hsl);
endmodule
